// ----- hw/rtl/hrnt_pkg.sv -----
// Shared constants and types of the hop-ranked neighbor table.
`default_nettype none
package hrnt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int MAX_HOPS      = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // operation codes
    localparam logic [2:0] K_INSERT   = 3'd0;
    localparam logic [2:0] K_LOOKUP   = 3'd1;
    localparam logic [2:0] K_REMOVE   = 3'd2;
    localparam logic [2:0] K_AGE      = 3'd3;
    localparam logic [2:0] K_CLEAR    = 3'd4;
    localparam logic [2:0] K_OLDEST   = 3'd5;
    localparam logic [2:0] K_LIST     = 3'd6;
    localparam logic [2:0] K_LIST_RLY = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOADDR  = 2'd3;

    typedef struct packed {
        logic [2:0]         level;
        logic [31:0]        addr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        relay;
        logic [63:0]        tstamp;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hrnt_mem.sv -----
// Entry store of the neighbor table: one write port, one registered read port.
`default_nettype none
module hrnt_mem
    import hrnt_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_ctl_t ctl,
    input  wire entry_t   wdata,
    output entry_t        rdata
);

    entry_t mem [TABLE_ENTRIES];

    // write entry
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
    end

    // read entry, hold data while read is idle
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata <= mem[ctl.raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/hop_ranked_neighbor_table.sv -----
// Hop-ranked neighbor table: one scan of the entry store per item that passes the checks.
// Scan items read the entry store through its single read port, one entry per cycle unless
// a list item stalls the scan: it holds a match, a new match returns and the output register
// is occupied. Rejected items (zero address or bad level) skip the scan to the final step.
// A new item is accepted only once the last one has left the final step.
// Reset clears all valid bits at once; the entry store itself needs no clearing.
`default_nettype none
module hop_ranked_neighbor_table
    import hrnt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic [31:0]        node_address,
    input  wire logic [2:0]         hop_level,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic [31:0]        relay_address,
    input  wire logic [63:0]        time_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [2:0]              found_level,
    output logic [31:0]             entry_address,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [31:0]             out_relay,
    output logic [63:0]             out_time,
    output logic                    last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // request registers
    entry_t     req_reg, req_next;
    logic [2:0] kind_reg, kind_next;
    logic       err_reg, err_next;
    logic [1:0] err_code_reg, err_code_next;

    // scan control
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0] ev_idx_reg, ev_idx_next;

    // scan results
    entry_t              best_reg, best_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic                best_vld_reg, best_vld_next;
    logic [63:0]         min_reg, min_next;
    logic [TABLE_ENTRIES-1:0] kill_reg, kill_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // output register
    logic        ov_reg, ov_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic [2:0]  o_lvl_reg, o_lvl_next;
    entry_t      o_ent_reg, o_ent_next;
    logic        o_last_reg, o_last_next;

    mem_ctl_t mem_ctl;
    entry_t   mem_wdata;
    entry_t   rdata;

    hrnt_mem u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    logic             out_free;
    logic             stall;
    logic             ev_v;
    logic             lvl_eq;
    logic             addr_eq;
    logic             list_match;
    logic             free_vld;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] tgt_idx;
    entry_t           zero_ent;

    assign out_free   = !ov_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign ev_v       = valid_reg[ev_idx_reg];
    assign lvl_eq     = (rdata.level == req_reg.level);
    assign addr_eq    = (rdata.addr == req_reg.addr);
    assign list_match = ev_vld_reg && ev_v && lvl_eq &&
                        (kind_reg == K_LIST || rdata.relay == req_reg.relay);
    assign stall      = (state_reg == S_SCAN) && (kind_reg == K_LIST || kind_reg == K_LIST_RLY)
                        && list_match && best_vld_reg && !out_free;
    assign zero_ent   = '0;
    assign tgt_idx    = best_vld_reg ? best_idx_reg : free_idx;

    // find lowest free slot
    always_comb
    begin
        free_vld = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_vld = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        kind_next     = kind_reg;
        err_next      = err_reg;
        err_code_next = err_code_reg;
        rd_cnt_next   = rd_cnt_reg;
        ev_vld_next   = ev_vld_reg;
        ev_idx_next   = ev_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        best_vld_next = best_vld_reg;
        min_next      = min_reg;
        kill_next     = kill_reg;
        valid_next    = valid_reg;
        ov_next       = ov_reg && !out_ready;
        o_st_next     = o_st_reg;
        o_lvl_next    = o_lvl_reg;
        o_ent_next    = o_ent_reg;
        o_last_next   = o_last_reg;
        mem_ctl       = '0;
        mem_wdata     = req_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next.level  = hop_level;
                    req_next.addr   = node_address;
                    req_next.x      = pos_x;
                    req_next.y      = pos_y;
                    req_next.z      = pos_z;
                    req_next.relay  = relay_address;
                    req_next.tstamp = time_value;
                    kind_next       = kind;
                    rd_cnt_next     = '0;
                    ev_vld_next     = 1'b0;
                    best_vld_next   = 1'b0;
                    min_next        = '1;
                    kill_next       = '0;
                    err_next        = 1'b1;
                    if (kind <= K_REMOVE && node_address == 32'd0)
                    begin
                        err_code_next = ST_NOADDR;
                        state_next    = S_DONE;
                    end
                    else if (kind != K_LOOKUP &&
                             (hop_level == 3'd0 || hop_level > 3'(MAX_HOPS)))
                    begin
                        err_code_next = ST_NONE;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    // issue next read
                    if (rd_cnt_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        mem_ctl.re    = 1'b1;
                        mem_ctl.raddr = rd_cnt_reg[IDX_W-1:0];
                        ev_vld_next   = 1'b1;
                        ev_idx_next   = rd_cnt_reg[IDX_W-1:0];
                        rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_vld_next = 1'b0;
                    end

                    // evaluate returned entry
                    if (ev_vld_reg && ev_v)
                    begin
                        case (kind_reg)
                            K_INSERT, K_LOOKUP:
                            begin
                                if (addr_eq && (!best_vld_reg || rdata.level < best_reg.level))
                                begin
                                    best_next     = rdata;
                                    best_idx_next = ev_idx_reg;
                                    best_vld_next = 1'b1;
                                end
                                if (addr_eq && rdata.level > req_reg.level)
                                begin
                                    kill_next[ev_idx_reg] = 1'b1;
                                end
                            end
                            K_REMOVE:
                            begin
                                if (!best_vld_reg && addr_eq && lvl_eq)
                                begin
                                    best_next              = rdata;
                                    best_vld_next          = 1'b1;
                                    valid_next[ev_idx_reg] = 1'b0;
                                end
                            end
                            K_AGE, K_CLEAR:
                            begin
                                if (lvl_eq && (kind_reg == K_CLEAR ||
                                               rdata.tstamp <= req_reg.tstamp))
                                begin
                                    valid_next[ev_idx_reg] = 1'b0;
                                end
                            end
                            K_OLDEST:
                            begin
                                if (lvl_eq)
                                begin
                                    best_vld_next = 1'b1;
                                    if (rdata.tstamp < min_reg)
                                    begin
                                        min_next = rdata.tstamp;
                                    end
                                end
                            end
                            default:
                            begin
                                // push held match out, keep the new one
                                if (list_match)
                                begin
                                    if (best_vld_reg)
                                    begin
                                        ov_next     = 1'b1;
                                        o_st_next   = ST_OK;
                                        o_lvl_next  = req_reg.level;
                                        o_ent_next  = best_reg;
                                        o_last_next = 1'b0;
                                    end
                                    best_next     = rdata;
                                    best_vld_next = 1'b1;
                                end
                            end
                        endcase
                    end

                    if (rd_cnt_reg == CNT_W'(TABLE_ENTRIES) && !ev_vld_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_last_next = 1'b1;
                    o_st_next   = ST_OK;
                    o_lvl_next  = 3'd0;
                    o_ent_next  = zero_ent;
                    state_next  = S_IDLE;
                    if (err_reg)
                    begin
                        o_st_next = err_code_reg;
                    end
                    else
                    begin
                        case (kind_reg)
                            K_INSERT:
                            begin
                                if (best_vld_reg && best_reg.level < req_reg.level)
                                begin
                                    o_lvl_next = best_reg.level;
                                    o_ent_next = best_reg;
                                end
                                else if (!best_vld_reg && !free_vld)
                                begin
                                    o_st_next = ST_FULL;
                                end
                                else
                                begin
                                    mem_ctl.we          = 1'b1;
                                    mem_ctl.waddr       = tgt_idx;
                                    valid_next          = valid_reg & ~kill_reg;
                                    valid_next[tgt_idx] = 1'b1;
                                    o_lvl_next          = req_reg.level;
                                    o_ent_next          = req_reg;
                                end
                            end
                            K_LOOKUP:
                            begin
                                if (best_vld_reg)
                                begin
                                    o_lvl_next = best_reg.level;
                                    o_ent_next = best_reg;
                                end
                                else
                                begin
                                    o_st_next = ST_NONE;
                                end
                            end
                            K_REMOVE, K_LIST, K_LIST_RLY:
                            begin
                                if (best_vld_reg)
                                begin
                                    o_lvl_next = req_reg.level;
                                    o_ent_next = best_reg;
                                end
                                else
                                begin
                                    o_st_next = ST_NONE;
                                end
                            end
                            K_OLDEST:
                            begin
                                o_ent_next.tstamp = min_reg;
                                if (best_vld_reg)
                                begin
                                    o_lvl_next = req_reg.level;
                                end
                                else
                                begin
                                    o_st_next = ST_NONE;
                                end
                            end
                            default:
                            begin
                                o_st_next = ST_OK;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            ov_reg     <= 1'b0;
            ev_vld_reg <= 1'b0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            ov_reg     <= ov_next;
            ev_vld_reg <= ev_vld_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        kind_reg     <= kind_next;
        err_reg      <= err_next;
        err_code_reg <= err_code_next;
        ev_idx_reg   <= ev_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        best_vld_reg <= best_vld_next;
        min_reg      <= min_next;
        kill_reg     <= kill_next;
        o_st_reg     <= o_st_next;
        o_lvl_reg    <= o_lvl_next;
        o_ent_reg    <= o_ent_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid     = ov_reg;
    assign status        = o_st_reg;
    assign found_level   = o_lvl_reg;
    assign entry_address = o_ent_reg.addr;
    assign out_x         = o_ent_reg.x;
    assign out_y         = o_ent_reg.y;
    assign out_z         = o_ent_reg.z;
    assign out_relay     = o_ent_reg.relay;
    assign out_time      = o_ent_reg.tstamp;
    assign last          = o_last_reg;

`ifndef ASSERT_OFF
    a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.we |-> state_reg == S_DONE)
        else $error("entry store written outside final step");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("scan counter past table end");

    a_eval_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> {1'b0, ev_idx_reg} < rd_cnt_reg)
        else $error("evaluated entry not yet read");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the hop-ranked neighbor table: random and directed items against a local model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrnt_pkg::*;

    typedef struct {
        bit                 mark;
        bit                 drain;
        int                 snd_pct;
        int                 rcv_pct;
        logic [2:0]         kind;
        logic [31:0]        addr;
        logic [2:0]         lvl;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        relay;
        logic [63:0]        tv;
    } op_t;

    typedef struct packed {
        logic [1:0]         st;
        logic [2:0]         lvl;
        logic [31:0]        addr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        relay;
        logic [63:0]        tv;
        logic               last;
    } reply_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         kind;
    logic [31:0]        node_address;
    logic [2:0]         hop_level;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        relay_address;
    logic [63:0]        time_value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [2:0]         found_level;
    logic [31:0]        entry_address;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_relay;
    logic [63:0]        out_time;
    logic               last;

    hop_ranked_neighbor_table u_top (.*);

    // table mirror
    bit                 nb_valid [TABLE_ENTRIES];
    logic [2:0]         nb_level [TABLE_ENTRIES];
    logic [31:0]        nb_addr  [TABLE_ENTRIES];
    logic signed [31:0] nb_x     [TABLE_ENTRIES];
    logic signed [31:0] nb_y     [TABLE_ENTRIES];
    logic signed [31:0] nb_z     [TABLE_ENTRIES];
    logic [31:0]        nb_relay [TABLE_ENTRIES];
    logic [63:0]        nb_time  [TABLE_ENTRIES];

    op_t    pending_ops[$];
    reply_t expected_replies[$];
    op_t    cur;
    bit     took_in;
    int     snd_pct;
    int     rcv_pct;
    int     errors;
    int     quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // append one item to the stimulus queue
    task automatic add_op(input op_t op);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // queue one reply; idx < 0 means no entry data
    task automatic expect_reply(input logic [1:0] st, input logic [2:0] lvl, input int idx,
                                input logic [63:0] t, input logic lst);
        reply_t r;
        r = '0;
        r.st = st;
        r.lvl = lvl;
        r.tv = t;
        r.last = lst;
        if (idx >= 0)
        begin
            r.addr = nb_addr[idx];
            r.x = nb_x[idx];
            r.y = nb_y[idx];
            r.z = nb_z[idx];
            r.relay = nb_relay[idx];
        end
        expected_replies.insert(expected_replies.size(), r);
    endtask

    function automatic int lowest_entry(input logic [31:0] a);
        int best;
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (nb_valid[i] && nb_addr[i] == a && (best < 0 || nb_level[i] < nb_level[best]))
                best = i;
        return best;
    endfunction

    // update the mirror and queue the replies of one accepted item
    task automatic predict_table_op(input op_t op);
        bit         lvl_ok;
        int         best;
        int         tgt;
        int         n;
        bit         any;
        logic [63:0] m;
        lvl_ok = op.lvl >= 1 && op.lvl <= MAX_HOPS;
        if (op.kind <= K_REMOVE && op.addr == 0)
        begin
            expect_reply(ST_NOADDR, 0, -1, 0, 1);
            return;
        end
        if (op.kind != K_LOOKUP && !lvl_ok)
        begin
            expect_reply(ST_NONE, 0, -1, 0, 1);
            return;
        end
        case (op.kind)
            K_INSERT:
            begin
                best = lowest_entry(op.addr);
                tgt = best;
                if (best >= 0 && nb_level[best] < op.lvl)
                begin
                    expect_reply(ST_OK, nb_level[best], best, nb_time[best], 1);
                    return;
                end
                if (best < 0)
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (!nb_valid[i] && tgt < 0)
                            tgt = i;
                if (tgt < 0)
                begin
                    expect_reply(ST_FULL, 0, -1, 0, 1);
                    return;
                end
                nb_valid[tgt] = 1;
                nb_level[tgt] = op.lvl;
                nb_addr[tgt] = op.addr;
                nb_x[tgt] = op.x;
                nb_y[tgt] = op.y;
                nb_z[tgt] = op.z;
                nb_relay[tgt] = op.relay;
                nb_time[tgt] = op.tv;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (i != tgt && nb_valid[i] && nb_addr[i] == op.addr && nb_level[i] > op.lvl)
                        nb_valid[i] = 0;
                expect_reply(ST_OK, op.lvl, tgt, op.tv, 1);
            end
            K_LOOKUP:
            begin
                best = lowest_entry(op.addr);
                if (best < 0)
                    expect_reply(ST_NONE, 0, -1, 0, 1);
                else
                    expect_reply(ST_OK, nb_level[best], best, nb_time[best], 1);
            end
            K_REMOVE:
            begin
                tgt = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tgt < 0 && nb_valid[i] && nb_level[i] == op.lvl && nb_addr[i] == op.addr)
                        tgt = i;
                if (tgt < 0)
                    expect_reply(ST_NONE, 0, -1, 0, 1);
                else
                begin
                    nb_valid[tgt] = 0;
                    expect_reply(ST_OK, op.lvl, tgt, nb_time[tgt], 1);
                end
            end
            K_AGE, K_CLEAR:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (nb_valid[i] && nb_level[i] == op.lvl &&
                        (op.kind == K_CLEAR || nb_time[i] <= op.tv))
                        nb_valid[i] = 0;
                expect_reply(ST_OK, 0, -1, 0, 1);
            end
            K_OLDEST:
            begin
                m = '1;
                any = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (nb_valid[i] && nb_level[i] == op.lvl)
                    begin
                        any = 1;
                        if (nb_time[i] < m)
                            m = nb_time[i];
                    end
                expect_reply(any ? ST_OK : ST_NONE, any ? op.lvl : 3'd0, -1, m, 1);
            end
            default:
            begin
                n = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (nb_valid[i] && nb_level[i] == op.lvl &&
                        (op.kind == K_LIST || nb_relay[i] == op.relay))
                    begin
                        expect_reply(ST_OK, op.lvl, i, nb_time[i], 0);
                        n++;
                    end
                if (n == 0)
                    expect_reply(ST_NONE, 0, -1, 0, 1);
                else
                    expected_replies[$].last = 1;
            end
        endcase
    endtask

    function automatic op_t mk(input logic [2:0] k, input logic [31:0] a, input logic [2:0] l,
                               input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                               input logic [31:0] r, input logic [63:0] t);
        op_t op;
        op = '{default: '0};
        op.kind = k;
        op.addr = a;
        op.lvl = l;
        op.x = x;
        op.y = y;
        op.z = z;
        op.relay = r;
        op.tv = t;
        return op;
    endfunction

    function automatic op_t marker(input bit drn, input int s, input int r);
        op_t op;
        op = '{default: '0};
        op.mark = 1;
        op.drain = drn;
        op.snd_pct = s;
        op.rcv_pct = r;
        return op;
    endfunction

    // random item over a small address and relay pool so entries get hit again
    function automatic op_t random_op();
        int         pick;
        logic [31:0] a;
        logic [2:0]  l;
        logic [31:0] r;
        logic [2:0]  k;
        pick = $urandom_range(99);
        if (pick < 40)
            k = K_INSERT;
        else if (pick < 55)
            k = K_LOOKUP;
        else if (pick < 65)
            k = K_REMOVE;
        else if (pick < 71)
            k = K_AGE;
        else if (pick < 74)
            k = K_CLEAR;
        else if (pick < 82)
            k = K_OLDEST;
        else if (pick < 91)
            k = K_LIST;
        else
            k = K_LIST_RLY;
        pick = $urandom_range(99);
        a = (pick < 3) ? 32'd0 : (pick < 6) ? $urandom : 32'(1 + $urandom_range(43));
        l = ($urandom_range(9) == 0) ? 3'(($urandom_range(3) == 0) ? 0 : 4 + $urandom_range(3))
                                     : 3'(1 + $urandom_range(3));
        r = ($urandom_range(5) == 0) ? $urandom : 32'(100 + $urandom_range(3));
        return mk(k, a, l, $urandom, $urandom, $urandom, r, {$urandom, $urandom});
    endfunction

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        kind = K_INSERT;
        node_address = '0;
        hop_level = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        relay_address = '0;
        time_value = '0;
        cur = '{default: '0};
        took_in = 0;
        snd_pct = 0;
        rcv_pct = 0;
        errors = 0;
        quiet_cycles = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            nb_valid[i] = 0;

        add_op(marker(0, 20, 74));
        // directed: extremes, special cases, every operation
        add_op(mk(K_INSERT, '1, 4, 32'h8000_0000, 32'h7fff_ffff, '1, '1, '1));
        add_op(mk(K_INSERT, 5, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0));
        add_op(mk(K_INSERT, 0, 1, 1, 2, 3, 4, 5));
        add_op(mk(K_LOOKUP, 0, 1, 0, 0, 0, 0, 0));
        add_op(mk(K_REMOVE, 0, 1, 0, 0, 0, 0, 0));
        add_op(mk(K_INSERT, 6, 0, 1, 1, 1, 1, 1));
        add_op(mk(K_INSERT, 6, 7, 1, 1, 1, 1, 1));
        add_op(mk(K_LIST, 0, 5, 0, 0, 0, 0, 0));
        add_op(mk(K_LOOKUP, 77, 0, 0, 0, 0, 0, 0));
        add_op(mk(K_INSERT, '1, 2, 9, 9, 9, 7, 100));
        add_op(mk(K_INSERT, '1, 3, 8, 8, 8, 7, 200));
        add_op(mk(K_LOOKUP, '1, 7, 0, 0, 0, 0, 0));
        add_op(mk(K_INSERT, 8, 2, -1, -2, -3, 7, 50));
        add_op(mk(K_OLDEST, 0, 2, 0, 0, 0, 0, 0));
        add_op(mk(K_OLDEST, 0, 3, 0, 0, 0, 0, 0));
        add_op(mk(K_LIST, 0, 2, 0, 0, 0, 0, 0));
        add_op(mk(K_LIST_RLY, 0, 2, 0, 0, 0, 7, 0));
        add_op(mk(K_LIST_RLY, 0, 2, 0, 0, 0, 8, 0));
        add_op(mk(K_REMOVE, 5, 2, 0, 0, 0, 0, 0));
        add_op(mk(K_REMOVE, 5, 1, 0, 0, 0, 0, 0));
        add_op(mk(K_AGE, 0, 2, 0, 0, 0, 0, 60));
        add_op(mk(K_LIST, 0, 2, 0, 0, 0, 0, 0));
        add_op(mk(K_CLEAR, 0, 2, 0, 0, 0, 0, 0));
        add_op(mk(K_AGE, 0, 0, 0, 0, 0, 0, 0));

        // empty the table, then fill it past capacity
        for (int l = 1; l <= MAX_HOPS; l++)
            add_op(mk(K_CLEAR, 0, 3'(l), 0, 0, 0, 0, 0));
        for (int i = 0; i < TABLE_ENTRIES + 3; i++)
            add_op(mk(K_INSERT, 32'(1000 + i), 3'(1 + $urandom_range(3)),
                      $urandom, $urandom, $urandom,
                      32'(100 + $urandom_range(3)), {$urandom, $urandom}));
        add_op(mk(K_LIST, 0, 1, 0, 0, 0, 0, 0));
        for (int i = 0; i < 70; i++)
            add_op(random_op());
        add_op(marker(0, 74, 20));
        for (int i = 0; i < 50; i++)
            add_op(random_op());
        add_op(marker(1, 74, 20));
        for (int i = 0; i < 50; i++)
            add_op(random_op());
        add_op(marker(1, 0, 0));
        for (int i = 0; i < 86; i++)
            add_op(random_op());

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // wait for the last item and its replies, then let the block settle
        do
            @(posedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0);
        repeat (80) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // driver: change inputs on the falling edge
    always @(negedge clk)
    begin
        bit nv;
        bit hold;
        if (rst_n)
        begin
            nv = in_valid && !took_in;
            hold = 0;
            if (!nv)
            begin
                while (!hold && pending_ops.size() != 0 && pending_ops[0].mark)
                begin
                    if (pending_ops[0].drain && expected_replies.size() != 0)
                        hold = 1;
                    else
                    begin
                        snd_pct = pending_ops[0].snd_pct;
                        rcv_pct = pending_ops[0].rcv_pct;
                        void'(pending_ops.pop_front());
                    end
                end
                if (!hold && pending_ops.size() != 0 && $urandom_range(99) >= snd_pct)
                begin
                    cur = pending_ops.pop_front();
                    nv = 1;
                    kind <= cur.kind;
                    node_address <= cur.addr;
                    hop_level <= cur.lvl;
                    pos_x <= cur.x;
                    pos_y <= cur.y;
                    pos_z <= cur.z;
                    relay_address <= cur.relay;
                    time_value <= cur.tv;
                end
            end
            in_valid <= nv;
            out_ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    // monitor: sample handshakes on the rising edge
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n)
        begin
            took_in = in_valid && in_ready;
            if (took_in)
                predict_table_op(cur);
            if (out_valid && out_ready)
            begin
                got = {status, found_level, entry_address, out_x, out_y, out_z,
                       out_relay, out_time, last};
                if (expected_replies.size() == 0)
                    report($sformatf("unexpected item %p", got));
                else
                begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                        report($sformatf("got %p want %p", got, want));
                end
            end
            // hang guard
            if (took_in || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 5000)
            begin
                $display("Timeout: no item moved for %0d cycles", quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
